>>> sv/ttsr_pkg.sv
// ttsr_pkg: shared widths, types and constants of the two touch scale and rotation block.
// Used by ttsr_cordic, ttsr_div, ttsr_sqrt and two_touch_scale_rotation.
// Depends on nothing.
package ttsr_pkg;

  localparam int DIFF_W     = 17;   // coordinate difference
  localparam int SQ_W       = 33;   // one squared difference
  localparam int DIST_W     = 34;   // squared distance
  localparam int Q_W        = 48;   // Q.32 squared ratio
  localparam int ROOT_W     = 24;   // Q8.16 ratio
  localparam int CV_W       = 28;   // CORDIC vector
  localparam int Z_W        = 26;   // angle, degrees Q.16
  localparam int ROT_W      = 28;   // angle difference, degrees Q.16
  localparam int OUT_ROT_W  = 18;
  localparam int MAX_STEPS  = 24;
  localparam int DIV_STEPS  = Q_W;
  localparam int SQRT_STEPS = ROOT_W;

  localparam logic [ROOT_W-1:0] SCALE_MAX = '1;
  localparam int ROT_MAX   = 92160;
  localparam int ANG_90    = 90 * 65536;
  localparam int ROUND_Q8  = 128;

  // atan(2^-i) in degrees Q.16, rounded to nearest
  localparam int ATAN_Q16 [MAX_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  typedef logic signed [CV_W-1:0]  cv_t;
  typedef logic signed [Z_W-1:0]   z_t;
  typedef logic signed [ROT_W-1:0] rot_t;

  // control that travels with one request down the scale path
  typedef struct packed {
    logic valid;
    logic zero;   // distance before the move is zero
    logic sat;    // ratio is 256 or more
  } sctl_t;

endpackage

>>> sv/ttsr_cordic.sv
// ttsr_cordic: pipelined vectoring CORDIC, angle of a difference vector in degrees Q.16.
// One quadrant fold stage, then one register stage per iteration.
// Depends on ttsr_pkg.
module ttsr_cordic #(
  parameter int NSTEP = 16
) (
  input  logic                                clk_i,
  input  logic signed [ttsr_pkg::DIFF_W-1:0]  dx_i,
  input  logic signed [ttsr_pkg::DIFF_W-1:0]  dy_i,
  output ttsr_pkg::z_t                        z_o,
  output logic                                zero_o
);
  import ttsr_pkg::*;

  cv_t  xg, yg;
  cv_t  x0_d, y0_d;
  z_t   z0_d;
  cv_t  x_q [NSTEP+1];
  cv_t  y_q [NSTEP+1];
  z_t   z_q [NSTEP+1];
  logic zero_q [NSTEP+1];

  assign xg = {{(CV_W-DIFF_W-8){dx_i[DIFF_W-1]}}, dx_i, 8'b0};
  assign yg = {{(CV_W-DIFF_W-8){dy_i[DIFF_W-1]}}, dy_i, 8'b0};

  // fold the left half plane onto the right
  always_comb begin
    x0_d = xg;
    y0_d = yg;
    z0_d = '0;
    if (xg < 0) begin
      if (yg >= 0) begin
        x0_d = yg;
        y0_d = -xg;
        z0_d = z_t'(ANG_90);
      end else begin
        x0_d = -yg;
        y0_d = xg;
        z0_d = -z_t'(ANG_90);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]    <= x0_d;
    y_q[0]    <= y0_d;
    z_q[0]    <= z0_d;
    zero_q[0] <= (dx_i == '0) && (dy_i == '0);
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_iter
    cv_t xs, ys;
    assign xs = x_q[k] >>> k;
    assign ys = y_q[k] >>> k;
    always_ff @(posedge clk_i) begin
      zero_q[k+1] <= zero_q[k];
      if (y_q[k] > 0) begin
        x_q[k+1] <= x_q[k] + ys;
        y_q[k+1] <= y_q[k] - xs;
        z_q[k+1] <= z_q[k] + z_t'(ATAN_Q16[k]);
      end else begin
        x_q[k+1] <= x_q[k] - ys;
        y_q[k+1] <= y_q[k] + xs;
        z_q[k+1] <= z_q[k] - z_t'(ATAN_Q16[k]);
      end
    end
  end

  assign z_o    = z_q[NSTEP];
  assign zero_o = zero_q[NSTEP];

endmodule

>>> sv/ttsr_div.sv
// ttsr_div: pipelined restoring divider, one quotient bit per register stage.
// Gives the Q.32 squared distance ratio; control rides along in sctl_t.
// Depends on ttsr_pkg.
module ttsr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttsr_pkg::sctl_t               ctl_i,
  input  logic [ttsr_pkg::DIST_W-1:0]   rem_i,
  input  logic [ttsr_pkg::Q_W-1:0]      dvd_i,
  input  logic [ttsr_pkg::DIST_W-1:0]   dvs_i,
  output ttsr_pkg::sctl_t               ctl_o,
  output logic [ttsr_pkg::Q_W-1:0]      q_o
);
  import ttsr_pkg::*;

  sctl_t             ctl_q [DIV_STEPS];
  logic [DIST_W-1:0] rem_q [DIV_STEPS];
  logic [Q_W-1:0]    dvd_q [DIV_STEPS];
  logic [DIST_W-1:0] dvs_q [DIV_STEPS];
  logic [Q_W-1:0]    q_q   [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
    sctl_t             ctl_in;
    logic [DIST_W-1:0] rem_in;
    logic [Q_W-1:0]    dvd_in;
    logic [DIST_W-1:0] dvs_in;
    logic [Q_W-1:0]    q_in;
    logic [DIST_W:0]   trial;
    logic              take;

    if (k == 0) begin : g_first
      assign ctl_in = ctl_i;
      assign rem_in = rem_i;
      assign dvd_in = dvd_i;
      assign dvs_in = dvs_i;
      assign q_in   = '0;
    end else begin : g_next
      assign ctl_in = ctl_q[k-1];
      assign rem_in = rem_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign q_in   = q_q[k-1];
    end

    assign trial = {rem_in, dvd_in[Q_W-1]};
    assign take  = trial >= {1'b0, dvs_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= take ? DIST_W'(trial - {1'b0, dvs_in}) : DIST_W'(trial);
      dvd_q[k] <= {dvd_in[Q_W-2:0], 1'b0};
      dvs_q[k] <= dvs_in;
      q_q[k]   <= {q_in[Q_W-2:0], take};
    end
  end

  assign ctl_o = ctl_q[DIV_STEPS-1];
  assign q_o   = q_q[DIV_STEPS-1];

endmodule

>>> sv/ttsr_sqrt.sv
// ttsr_sqrt: pipelined digit-by-digit integer square root, one root bit per stage.
// Turns the Q.32 squared ratio into the Q8.16 ratio; control rides along.
// Depends on ttsr_pkg.
module ttsr_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttsr_pkg::sctl_t               ctl_i,
  input  logic [ttsr_pkg::Q_W-1:0]      val_i,
  output ttsr_pkg::sctl_t               ctl_o,
  output logic [ttsr_pkg::ROOT_W-1:0]   root_o
);
  import ttsr_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  sctl_t             ctl_q  [SQRT_STEPS];
  logic [REM_W-1:0]  rem_q  [SQRT_STEPS];
  logic [Q_W-1:0]    val_q  [SQRT_STEPS];
  logic [ROOT_W-1:0] root_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_st
    sctl_t             ctl_in;
    logic [REM_W-1:0]  rem_in;
    logic [Q_W-1:0]    val_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  test;
    logic              take;

    if (k == 0) begin : g_first
      assign ctl_in  = ctl_i;
      assign rem_in  = '0;
      assign val_in  = val_i;
      assign root_in = '0;
    end else begin : g_next
      assign ctl_in  = ctl_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign val_in  = val_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign trial = {rem_in, val_in[Q_W-1 -: 2]};
    assign test  = {2'b00, root_in, 2'b01};
    assign take  = trial >= test;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[k] <= '0;
      end else begin
        ctl_q[k] <= ctl_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? REM_W'(trial - test) : REM_W'(trial);
      val_q[k]  <= {val_in[Q_W-3:0], 2'b00};
      root_q[k] <= {root_in[ROOT_W-2:0], take};
    end
  end

  assign ctl_o  = ctl_q[SQRT_STEPS-1];
  assign root_o = root_q[SQRT_STEPS-1];

endmodule

>>> sv/two_touch_scale_rotation.sv
// two_touch_scale_rotation: top level, pinch zoom scale and rotation of two touches.
// Instantiates ttsr_cordic (twice), ttsr_div and ttsr_sqrt; depends on ttsr_pkg.
//
// Usage:
//   Drive the anchor, previous and current touch coordinates and raise start_i.
//   A request is taken at every rising edge with start_i high and busy_o low.
//   busy_o stays low: the datapath is a free running pipeline that takes one
//   request per cycle, back to back, for as long as start_i stays high.
//   For every request done_o pulses for one cycle with scale_ratio_o and
//   rotation_deg_o. Results leave in request order.
//   The depth is set by the scale path: four front stages (differences,
//   squares, distance sums, range flags), a 48 stage restoring divider and a
//   24 stage square root, then the output register. The angle path (two
//   CORDIC pipelines, fold plus CORDIC_STEPS stages) is delayed to match.
//   The receiver cannot hold results off; it must take done_o as it comes.
//   Reset clears every valid bit; requests in flight are dropped.
module two_touch_scale_rotation #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  output logic                                  busy_o,
  input  logic signed [15:0]                    anchor_x_i,
  input  logic signed [15:0]                    anchor_y_i,
  input  logic signed [15:0]                    prev_x_i,
  input  logic signed [15:0]                    prev_y_i,
  input  logic signed [15:0]                    cur_x_i,
  input  logic signed [15:0]                    cur_y_i,
  output logic                                  done_o,
  output logic [ttsr_pkg::ROOT_W-1:0]           scale_ratio_o,
  output logic signed [ttsr_pkg::OUT_ROT_W-1:0] rotation_deg_o
);
  import ttsr_pkg::*;

  localparam int NSTEP   = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
  localparam int LAT     = 4 + DIV_STEPS + SQRT_STEPS + 1;
  localparam int ROT_DLY = LAT - NSTEP - 4;

  // stage 1: differences about the anchor
  logic                     v1_q;
  logic signed [DIFF_W-1:0] bx_q, by_q, cx_q, cy_q;
  // stage 2: squares
  logic                     v2_q;
  logic [SQ_W-1:0]          sbx_q, sby_q, scx_q, scy_q;
  // stage 3: squared distances
  logic                     v3_q;
  logic [DIST_W-1:0]        db_q, da_q;
  // stage 4: range flags and divider setup
  sctl_t                    ctl4_q;
  logic [DIST_W-1:0]        rem4_q, dvs4_q;
  logic [Q_W-1:0]           dvd4_q;
  // divider and root
  sctl_t                    div_ctl, sq_ctl;
  logic [Q_W-1:0]           div_q;
  logic [ROOT_W-1:0]        root;
  // angle path
  z_t                       zb, zc;
  logic                     zb_zero, zc_zero;
  rot_t                     diff_q;
  rot_t                     dly_q [ROT_DLY];
  rot_t                     rnd;
  rot_t                     clamped;
  // output
  logic                     done_q;
  logic [ROOT_W-1:0]        scale_q;
  logic signed [OUT_ROT_W-1:0] rot_q;

  assign busy_o = 1'b0;

  // valid bits of the front stages, range flags and done_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      ctl4_q <= '0;
      done_q <= 1'b0;
    end else begin
      v1_q         <= start_i && !busy_o;
      v2_q         <= v1_q;
      v3_q         <= v2_q;
      ctl4_q.valid <= v3_q;
      ctl4_q.zero  <= (db_q == '0);
      // ratio of 256 or more: after >= before * 2^16
      ctl4_q.sat   <= ({16'b0, da_q} >= {db_q, 16'b0});
      done_q       <= sq_ctl.valid;
    end
  end

  // front datapath
  always_ff @(posedge clk_i) begin
    bx_q   <= $signed({prev_x_i[15], prev_x_i}) - $signed({anchor_x_i[15], anchor_x_i});
    by_q   <= $signed({prev_y_i[15], prev_y_i}) - $signed({anchor_y_i[15], anchor_y_i});
    cx_q   <= $signed({cur_x_i[15], cur_x_i}) - $signed({anchor_x_i[15], anchor_x_i});
    cy_q   <= $signed({cur_y_i[15], cur_y_i}) - $signed({anchor_y_i[15], anchor_y_i});
    sbx_q  <= SQ_W'(bx_q * bx_q);
    sby_q  <= SQ_W'(by_q * by_q);
    scx_q  <= SQ_W'(cx_q * cx_q);
    scy_q  <= SQ_W'(cy_q * cy_q);
    db_q   <= DIST_W'(sbx_q) + DIST_W'(sby_q);
    da_q   <= DIST_W'(scx_q) + DIST_W'(scy_q);
    // quotient bits above 2^47 are zero when not saturated: preload them
    rem4_q <= DIST_W'(da_q[DIST_W-1:16]);
    dvd4_q <= {da_q[15:0], 32'b0};
    dvs4_q <= db_q;
  end

  ttsr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl4_q),
    .rem_i  (rem4_q),
    .dvd_i  (dvd4_q),
    .dvs_i  (dvs4_q),
    .ctl_o  (div_ctl),
    .q_o    (div_q)
  );

  ttsr_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .val_i  (div_q),
    .ctl_o  (sq_ctl),
    .root_o (root)
  );

  // angles before and after the move
  ttsr_cordic #(.NSTEP(NSTEP)) u_cordic_b (
    .clk_i  (clk_i),
    .dx_i   (bx_q),
    .dy_i   (by_q),
    .z_o    (zb),
    .zero_o (zb_zero)
  );

  ttsr_cordic #(.NSTEP(NSTEP)) u_cordic_c (
    .clk_i  (clk_i),
    .dx_i   (cx_q),
    .dy_i   (cy_q),
    .z_o    (zc),
    .zero_o (zc_zero)
  );

  // negated angle change; a zero vector counts as angle zero
  always_ff @(posedge clk_i) begin
    diff_q <= (zb_zero ? rot_t'(0) : rot_t'(zb)) - (zc_zero ? rot_t'(0) : rot_t'(zc));
    dly_q[0] <= diff_q;
    for (int i = 1; i < ROT_DLY; i++) begin
      dly_q[i] <= dly_q[i-1];
    end
  end

  // round to Q.8 and clamp
  always_comb begin
    rnd     = (dly_q[ROT_DLY-1] + rot_t'(ROUND_Q8)) >>> 8;
    clamped = rnd;
    if (rnd > rot_t'(ROT_MAX)) begin
      clamped = rot_t'(ROT_MAX);
    end else if (rnd < -rot_t'(ROT_MAX)) begin
      clamped = -rot_t'(ROT_MAX);
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_ctl.zero) begin
      scale_q <= '0;
    end else if (sq_ctl.sat) begin
      scale_q <= SCALE_MAX;
    end else begin
      scale_q <= root;
    end
    rot_q <= OUT_ROT_W'(clamped);
  end

  assign done_o         = done_q;
  assign scale_ratio_o  = scale_q;
  assign rotation_deg_o = rot_q;

  // every request comes out after a fixed latency
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##LAT done_o)
    else $error("request did not complete after fixed latency");

  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, LAT))
    else $error("result without a matching request");

  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rotation_deg_o <= OUT_ROT_W'(ROT_MAX)) &&
               (rotation_deg_o >= -OUT_ROT_W'(ROT_MAX)))
    else $error("rotation out of range");

endmodule

>>> verif/testbench.sv
// Testbench for two_touch_scale_rotation: pinch scale and rotation of two touches.
// Drives requests from a queue, predicts scale and rotation, and checks each done_o result.
// Depends on ttsr_pkg and two_touch_scale_rotation.
`timescale 1ns / 1ps

module testbench;
  import ttsr_pkg::*;

  localparam int STEPS    = 16;
  localparam int LATENCY  = 77;
  localparam int WDOG_MAX = 4000;

  typedef struct packed {
    logic signed [15:0] ax, ay, px, py, cx, cy;
  } touch_t;

  typedef struct packed {
    logic [ROOT_W-1:0]           scale;
    logic signed [OUT_ROT_W-1:0] rot;
  } gesture_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o, done_o;
  logic signed [15:0] anchor_x_i = '0, anchor_y_i = '0, prev_x_i = '0;
  logic signed [15:0] prev_y_i = '0, cur_x_i = '0, cur_y_i = '0;
  logic [ROOT_W-1:0] scale_ratio_o;
  logic signed [OUT_ROT_W-1:0] rotation_deg_o;

  touch_t   pending_q[$];
  gesture_t gesture_q[$];
  int  send_idle_pct = 14;
  bit  hold_send = 1'b0;
  bit  stim_done = 1'b0;
  int  errors = 0;
  int  quiet_cycles = 0;

  two_touch_scale_rotation #(.CORDIC_STEPS(STEPS)) dut (.*);

  always #6 clk_i = ~clk_i;

  // Floor shift right for signed values.
  function automatic longint asr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // Angle of (x, y) about the anchor, degrees Q.16, vectoring CORDIC.
  function automatic longint touch_angle(longint x, longint y);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 256;
    y = y * 256;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = ANG_90;
      end else begin
        t = x; x = -y; y = t; z = -ANG_90;
      end
    end
    for (int i = 0; i < STEPS && i < MAX_STEPS; i++) begin
      xs = asr_floor(x, i);
      ys = asr_floor(y, i);
      if (y > 0) begin
        x = x + ys; y = y - xs; z += ATAN_Q16[i];
      end else begin
        x = x - ys; y = y + xs; z -= ATAN_Q16[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [ROOT_W-1:0] pinch_scale(longint unsigned da, longint unsigned db);
    longint unsigned q1, r, q2, q3, q;
    if (db == 0) return '0;
    if (da >= (db << 16)) return SCALE_MAX;
    q1 = da / db;
    r = (da % db) << 16;
    q2 = r / db;
    r = (r % db) << 16;
    q3 = r / db;
    q = int_root((q1 << 32) | (q2 << 16) | q3);
    if (q > 64'hFFFFFF) q = 64'hFFFFFF;
    return q[ROOT_W-1:0];
  endfunction

  function automatic gesture_t predict_gesture(touch_t t);
    longint bx, by, cx, cy, rot;
    gesture_t g;
    bx = longint'(t.px) - t.ax;
    by = longint'(t.py) - t.ay;
    cx = longint'(t.cx) - t.ax;
    cy = longint'(t.cy) - t.ay;
    rot = touch_angle(bx, by) - touch_angle(cx, cy);
    rot = asr_floor(rot + ROUND_Q8, 8);
    if (rot > ROT_MAX) rot = ROT_MAX;
    if (rot < -ROT_MAX) rot = -ROT_MAX;
    g.rot = rot[OUT_ROT_W-1:0];
    g.scale = pinch_scale(cx * cx + cy * cy, bx * bx + by * by);
    return g;
  endfunction

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'($urandom_range(0, 64) - 32);
      default: return 16'($urandom());
    endcase
  endfunction

  // Moving touch mostly kept near the anchor so scale and rotation stay meaningful; one draw in four is fully random.
  function automatic touch_t rand_touch();
    touch_t t;
    int span;
    t.ax = rand_coord();
    t.ay = rand_coord();
    if ($urandom_range(0, 3) == 0) begin
      t.px = rand_coord(); t.py = rand_coord();
      t.cx = rand_coord(); t.cy = rand_coord();
    end else begin
      span = 1 << $urandom_range(1, 14);
      t.px = 16'(t.ax + $signed($urandom_range(0, 2 * span)) - span);
      t.py = 16'(t.ay + $signed($urandom_range(0, 2 * span)) - span);
      t.cx = 16'(t.ax + $signed($urandom_range(0, 2 * span)) - span);
      t.cy = 16'(t.ay + $signed($urandom_range(0, 2 * span)) - span);
    end
    return t;
  endfunction

  // Driver: advance to the next request once the current one is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!(start_i && !busy_o) && start_i) begin
        // hold the request until taken
      end else if (pending_q.size() > 0 && !hold_send &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        start_i    <= 1'b1;
        anchor_x_i <= pending_q[0].ax;
        anchor_y_i <= pending_q[0].ay;
        prev_x_i   <= pending_q[0].px;
        prev_y_i   <= pending_q[0].py;
        cur_x_i    <= pending_q[0].cx;
        cur_y_i    <= pending_q[0].cy;
        gesture_q.push_back(predict_gesture(pending_q.pop_front()));
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: check each result against the oldest prediction.
  always @(posedge clk_i) begin
    gesture_t exp_g;
    if (rst_ni && done_o) begin
      if (gesture_q.size() == 0) begin
        $error("unexpected result scale=%0d rot=%0d", scale_ratio_o, rotation_deg_o);
        errors++;
      end else begin
        exp_g = gesture_q.pop_front();
        if (scale_ratio_o !== exp_g.scale) begin
          $error("scale_ratio expected %0d actual %0d", exp_g.scale, scale_ratio_o);
          errors++;
        end
        if (rotation_deg_o !== exp_g.rot) begin
          $error("rotation_deg expected %0d actual %0d", exp_g.rot, rotation_deg_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: drop the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) quiet_cycles <= 0;
    else if (!stim_done) quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || start_i) @(posedge clk_i);
    while (gesture_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    touch_t t;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: zero distances, saturation, axes, extremes.
    pending_q.push_back('{0, 0, 0, 0, 0, 0});
    pending_q.push_back('{0, 0, 0, 0, 5, 5});
    pending_q.push_back('{0, 0, 5, 5, 0, 0});
    pending_q.push_back('{0, 0, 1, 0, 32767, 0});
    pending_q.push_back('{0, 0, 1, 0, 255, 0});
    pending_q.push_back('{0, 0, 1, 0, 256, 0});
    pending_q.push_back('{0, 0, 10, 0, -10, 0});
    pending_q.push_back('{0, 0, -10, 0, 10, 0});
    pending_q.push_back('{0, 0, -10, 1, -10, -1});
    pending_q.push_back('{0, 0, 0, 10, 0, -10});
    pending_q.push_back('{0, 0, -7, 3, 7, 3});
    pending_q.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000});
    pending_q.push_back('{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF});
    pending_q.push_back('{16'sh8000, 0, 16'sh7FFF, 0, 16'sh7FFF, 1});
    pending_q.push_back('{100, -200, 130, -160, 100, -150});
    pending_q.push_back('{-1, -1, -1, -1, -1, -1});
    drain();
    // Every result is back now; pause the sender, then go random.
    hold_send = 1'b1;
    repeat (20) @(posedge clk_i);
    hold_send = 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 83 : 0;
      for (int n = 0; n < 410; n++) begin
        t = rand_touch();
        pending_q.push_back(t);
      end
      drain();
    end
    stim_done = 1'b1;
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && gesture_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
